### rtl/ftff_pkg.sv
// Shared widths, codes and types for the freeze/thaw front finder.
package ftff_pkg;

    localparam int TEMP_W  = 20;
    localparam int DEPTH_W = 20;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int KIND_W  = 2;

    // magnitudes of 21-bit signed differences
    localparam int OP_W  = TEMP_W + 1;
    localparam int MUL_W = 2 * OP_W;

    localparam int FRONT_LIMIT_DEF = 3;

    localparam logic signed [TEMP_W-1:0] THR_RESET = 20'sd69926;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_THAW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FROST = 2'd2;

    // operands for one interpolation: |thr - Tu|, |Dl - Du|, |Tl - Tu|
    typedef struct packed {
        logic [OP_W-1:0] a_mag;
        logic [OP_W-1:0] b_mag;
        logic [OP_W-1:0] den_mag;
    } interp_op_t;

endpackage

### rtl/freeze_thaw_front_finder.sv
// Top level of the freeze/thaw front finder: node pairing, front counts, result register.
// For a node with no front the request goes straight to the result register; a front first
//   passes the multiply and the 20 restoring divide steps in ftff_interp, then the handoff.
// Throughput: one request at a time; s_ready is high only while the sequencer is idle.
//   A finished result waiting in the output register does not block the next request.
// Reset (aresetn, synchronous, active low): threshold back to 69926, counts and the
//   stored lower node cleared, no result pending.
module freeze_thaw_front_finder #(
    parameter int FRONT_LIMIT = ftff_pkg::FRONT_LIMIT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic signed [ftff_pkg::TEMP_W-1:0] cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ftff_pkg::TEMP_W-1:0] s_node_temp,
    input  logic [ftff_pkg::DEPTH_W-1:0]       s_node_depth,
    input  logic                               s_profile_start,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ftff_pkg::KIND_W-1:0]        m_front_kind,
    output logic [ftff_pkg::DEPTH_W-1:0]       m_front_depth,
    output logic [ftff_pkg::SLOT_W-1:0]        m_front_slot,
    output logic [ftff_pkg::COUNT_W-1:0]       m_thaw_count,
    output logic [ftff_pkg::COUNT_W-1:0]       m_frost_count
);

    localparam int TW  = ftff_pkg::TEMP_W;
    localparam int DW  = ftff_pkg::DEPTH_W;
    localparam int CW  = ftff_pkg::COUNT_W;
    localparam int SW  = ftff_pkg::SLOT_W;
    localparam int KW  = ftff_pkg::KIND_W;
    localparam int OPW = ftff_pkg::OP_W;
    localparam logic [CW-1:0] LIMIT = CW'(FRONT_LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic signed [TW-1:0]  thr_reg, thr_next;
    logic signed [TW-1:0]  lower_temp_reg, lower_temp_next;
    logic [DW-1:0]         lower_depth_reg, lower_depth_next;
    logic                  have_lower_reg, have_lower_next;
    logic [CW-1:0]         thaw_reg, thaw_next;
    logic [CW-1:0]         frost_reg, frost_next;

    // per-request working values
    logic [KW-1:0]         kind_reg, kind_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [DW-1:0]         du_reg, du_next;
    logic                  neg_reg, neg_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [KW-1:0]         m_kind_reg, m_kind_next;
    logic [DW-1:0]         m_depth_reg, m_depth_next;
    logic [SW-1:0]         m_slot_reg, m_slot_next;
    logic [CW-1:0]         m_thaw_reg, m_thaw_next;
    logic [CW-1:0]         m_frost_reg, m_frost_next;

    logic                  accept;
    logic                  thaw_hit, frost_hit;
    logic signed [OPW-1:0] a_diff, b_diff, den_diff;
    ftff_pkg::interp_op_t  iop;
    logic                  i_done;
    logic [DW-1:0]         i_quot;
    logic [DW-1:0]         offset;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Upper node is the incoming one, lower node is the stored one.
    assign thaw_hit  = have_lower_reg && !s_profile_start && (s_node_temp > thr_reg)
                       && (lower_temp_reg <= thr_reg) && (thaw_reg < LIMIT);
    assign frost_hit = have_lower_reg && !s_profile_start && (s_node_temp < thr_reg)
                       && (lower_temp_reg >= thr_reg) && (frost_reg < LIMIT);

    // Signs cancel between numerator and divisor except for the depth span,
    // so the unit works on magnitudes and the depth span sign is applied after.
    assign a_diff   = OPW'(thr_reg) - OPW'(s_node_temp);
    assign b_diff   = $signed({1'b0, lower_depth_reg}) - $signed({1'b0, s_node_depth});
    assign den_diff = OPW'(lower_temp_reg) - OPW'(s_node_temp);

    assign iop.a_mag   = a_diff[OPW-1]   ? OPW'(-a_diff)   : OPW'(a_diff);
    assign iop.b_mag   = b_diff[OPW-1]   ? OPW'(-b_diff)   : OPW'(b_diff);
    assign iop.den_mag = den_diff[OPW-1] ? OPW'(-den_diff) : OPW'(den_diff);

    ftff_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (thaw_hit || frost_hit)),
        .op      (iop),
        .done    (i_done),
        .quot    (i_quot)
    );

    assign offset = neg_reg ? (~i_quot + DW'(1)) : i_quot;

    always_comb begin
        state_next       = state_reg;
        thr_next         = thr_reg;
        lower_temp_next  = lower_temp_reg;
        lower_depth_next = lower_depth_reg;
        have_lower_next  = have_lower_reg;
        thaw_next        = thaw_reg;
        frost_next       = frost_reg;
        kind_next        = kind_reg;
        slot_next        = slot_reg;
        du_next          = du_reg;
        neg_next         = neg_reg;
        m_valid_next     = m_valid_reg;
        m_kind_next      = m_kind_reg;
        m_depth_next     = m_depth_reg;
        m_slot_next      = m_slot_reg;
        m_thaw_next      = m_thaw_reg;
        m_frost_next     = m_frost_reg;

        if (cfg_wr_en) begin
            thr_next = cfg_wr_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    lower_temp_next  = s_node_temp;
                    lower_depth_next = s_node_depth;
                    have_lower_next  = 1'b1;
                    du_next          = s_node_depth;
                    neg_next         = b_diff[OPW-1];
                    kind_next        = ftff_pkg::KIND_NONE;
                    slot_next        = '0;
                    if (s_profile_start) begin
                        thaw_next  = '0;
                        frost_next = '0;
                    end else if (thaw_hit) begin
                        kind_next = ftff_pkg::KIND_THAW;
                        slot_next = thaw_reg[SW-1:0];
                        thaw_next = thaw_reg + CW'(1);
                    end else if (frost_hit) begin
                        kind_next  = ftff_pkg::KIND_FROST;
                        slot_next  = frost_reg[SW-1:0];
                        frost_next = frost_reg + CW'(1);
                    end
                    state_next = (thaw_hit || frost_hit) ? ST_CALC : ST_OUT;
                end
            end
            ST_CALC: begin
                if (i_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // quotient stays valid in the unit until its next start
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_slot_next  = slot_reg;
                    m_depth_next = (kind_reg == ftff_pkg::KIND_NONE) ? '0
                                                                     : du_reg + offset;
                    m_thaw_next  = thaw_reg;
                    m_frost_next = frost_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            thr_reg         <= ftff_pkg::THR_RESET;
            lower_temp_reg  <= '0;
            lower_depth_reg <= '0;
            have_lower_reg  <= 1'b0;
            thaw_reg        <= '0;
            frost_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            thr_reg         <= thr_next;
            lower_temp_reg  <= lower_temp_next;
            lower_depth_reg <= lower_depth_next;
            have_lower_reg  <= have_lower_next;
            thaw_reg        <= thaw_next;
            frost_reg       <= frost_next;
            m_valid_reg     <= m_valid_next;
        end
        kind_reg    <= kind_next;
        slot_reg    <= slot_next;
        du_reg      <= du_next;
        neg_reg     <= neg_next;
        m_kind_reg  <= m_kind_next;
        m_depth_reg <= m_depth_next;
        m_slot_reg  <= m_slot_next;
        m_thaw_reg  <= m_thaw_next;
        m_frost_reg <= m_frost_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_front_kind  = m_kind_reg;
    assign m_front_depth = m_depth_reg;
    assign m_front_slot  = m_slot_reg;
    assign m_thaw_count  = m_thaw_reg;
    assign m_frost_count = m_frost_reg;

    // divider finishes only while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        i_done |-> (state_reg == ST_CALC))
        else $error("interp done outside CALC");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (thaw_reg <= LIMIT) && (frost_reg <= LIMIT))
        else $error("front count above limit");

    a_thaw_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_front_kind == ftff_pkg::KIND_THAW))
            |-> (CW'(m_front_slot) < m_thaw_count))
        else $error("thaw slot not below thaw count");

    a_frost_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_front_kind == ftff_pkg::KIND_FROST))
            |-> (CW'(m_front_slot) < m_frost_count))
        else $error("frost slot not below frost count");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while still busy");

endmodule

### rtl/ftff_interp.sv
// Multiply then restoring shift-subtract divide for the front offset magnitude.
module ftff_interp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  ftff_pkg::interp_op_t           op,
    output logic                           done,
    output logic [ftff_pkg::DEPTH_W-1:0]   quot
);

    localparam int QW    = ftff_pkg::DEPTH_W;
    localparam int OPW   = ftff_pkg::OP_W;
    localparam int MW    = ftff_pkg::MUL_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } ustate_t;

    ustate_t              state_reg, state_next;
    logic [OPW-1:0]       a_reg, a_next;
    logic [OPW-1:0]       b_reg, b_next;
    logic [OPW-1:0]       den_reg, den_next;
    logic [OPW-1:0]       rem_reg, rem_next;
    logic [QW-1:0]        low_reg, low_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [MW-1:0]        prod;
    logic [OPW:0]         rem_sh;
    logic [OPW:0]         diff;
    logic                 ge;

    assign prod   = a_reg * b_reg;
    assign rem_sh = {rem_reg, low_reg[QW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    a_next     = op.a_mag;
                    b_next     = op.b_mag;
                    den_next   = op.den_mag;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                // quotient < 2^QW, so the upper part is already below the divisor
                rem_next   = prod[QW+OPW-1:QW];
                low_next   = prod[QW-1:0];
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV: begin
                rem_next = ge ? diff[OPW-1:0] : rem_sh[OPW-1:0];
                low_next = {low_reg[QW-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

### bench/ftff_front_checker.sv
// Checker for the freeze/thaw front finder: predicts front reports and scores the result channel.
module ftff_front_checker
    import ftff_pkg::*;
#(
    parameter int FRONT_LIMIT = FRONT_LIMIT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic signed [TEMP_W-1:0]  cfg_wr_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [TEMP_W-1:0]  s_node_temp,
    input  logic [DEPTH_W-1:0]        s_node_depth,
    input  logic                      s_profile_start,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [KIND_W-1:0]         m_front_kind,
    input  logic [DEPTH_W-1:0]        m_front_depth,
    input  logic [SLOT_W-1:0]         m_front_slot,
    input  logic [COUNT_W-1:0]        m_thaw_count,
    input  logic [COUNT_W-1:0]        m_frost_count,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DEPTH_W-1:0] depth;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] thaw;
        logic [COUNT_W-1:0] frost;
    } front_report_t;

    front_report_t            front_reports[$];
    logic signed [TEMP_W-1:0] threshold;
    logic signed [TEMP_W-1:0] below_temp;
    logic [DEPTH_W-1:0]       below_depth;
    logic                     below_seen;
    int                       thaw_tally;
    int                       frost_tally;
    int                       errors;

    // linear interpolation at the threshold, quotient truncated toward zero
    function automatic logic [DEPTH_W-1:0] front_depth_at(int thr, int tu, int tl,
                                                          int du, int dl);
        longint num;
        longint den;
        longint off;
        num = longint'(thr - tu) * longint'(dl - du);
        den = longint'(tl - tu);
        off = (den == 0) ? 0 : num / den;
        return DEPTH_W'(longint'(du) + off);
    endfunction

    function automatic front_report_t predict_front(logic signed [TEMP_W-1:0] t,
                                                    logic [DEPTH_W-1:0] d, logic start);
        front_report_t r;
        r = '0;
        if (start) begin
            thaw_tally  = 0;
            frost_tally = 0;
        end else if (below_seen) begin
            if (t > threshold && below_temp <= threshold && thaw_tally < FRONT_LIMIT) begin
                r.kind  = KIND_THAW;
                r.depth = front_depth_at(threshold, t, below_temp, d, below_depth);
                r.slot  = SLOT_W'(thaw_tally);
                thaw_tally++;
            end else if (t < threshold && below_temp >= threshold
                         && frost_tally < FRONT_LIMIT) begin
                r.kind  = KIND_FROST;
                r.depth = front_depth_at(threshold, t, below_temp, d, below_depth);
                r.slot  = SLOT_W'(frost_tally);
                frost_tally++;
            end
        end
        below_temp  = t;
        below_depth = d;
        below_seen  = 1'b1;
        r.thaw      = COUNT_W'(thaw_tally);
        r.frost     = COUNT_W'(frost_tally);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        front_report_t want;
        front_report_t got;
        if (!aresetn) begin
            threshold   = THR_RESET;
            below_temp  = '0;
            below_depth = '0;
            below_seen  = 1'b0;
            thaw_tally  = 0;
            frost_tally = 0;
            front_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                threshold = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                front_reports.push_back(predict_front(s_node_temp, s_node_depth,
                                                      s_profile_start));
            end
            if (m_valid && m_ready) begin
                got = {m_front_kind, m_front_depth, m_front_slot, m_thaw_count, m_frost_count};
                if (front_reports.size() == 0) begin
                    errors++;
                    if (errors <= 20) begin
                        $display("%0t: unrequested result, expected none,", $time,
                                 " got kind=%0d depth=%0d slot=%0d thaw=%0d frost=%0d",
                                 got.kind, got.depth, got.slot, got.thaw, got.frost);
                    end
                end else begin
                    want = front_reports.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 20) begin
                            $display("%0t: front mismatch,", $time,
                                     " expected kind=%0d depth=%0d slot=%0d",
                                     want.kind, want.depth, want.slot,
                                     " thaw=%0d frost=%0d,", want.thaw, want.frost,
                                     " got kind=%0d depth=%0d slot=%0d",
                                     got.kind, got.depth, got.slot,
                                     " thaw=%0d frost=%0d", got.thaw, got.frost);
                        end
                    end
                end
            end
        end
        pending    <= front_reports.size();
        fail_count <= errors;
    end

endmodule

### bench/tb_freeze_thaw_front_finder.sv
// Testbench top for the freeze/thaw front finder: stimulus, receiver back-pressure and verdict.
module tb_freeze_thaw_front_finder;
    import ftff_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRONT_LIMIT  = FRONT_LIMIT_DEF;
    localparam int TEMP_MAX     = 524287;
    localparam int TEMP_MIN     = -524288;
    localparam int DEPTH_MAX    = 1048575;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 285;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 64;
    localparam int RUN_LIMIT_NS = 10_000_000;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     cfg_wr_en       = 1'b0;
    logic signed [TEMP_W-1:0] cfg_wr_data     = '0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic signed [TEMP_W-1:0] s_node_temp     = '0;
    logic [DEPTH_W-1:0]       s_node_depth    = '0;
    logic                     s_profile_start = 1'b0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [KIND_W-1:0]        m_front_kind;
    logic [DEPTH_W-1:0]       m_front_depth;
    logic [SLOT_W-1:0]        m_front_slot;
    logic [COUNT_W-1:0]       m_thaw_count;
    logic [COUNT_W-1:0]       m_frost_count;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    int cur_thr     = 0;
    int items_sent  = 0;
    int rush_left   = 0;
    // receiver control; the stimulus side writes these nonblocking so the sink sees them cleanly
    int holds_asked = 0;
    int holds_done  = 0;
    bit calm        = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    freeze_thaw_front_finder #(
        .FRONT_LIMIT(FRONT_LIMIT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_node_temp    (s_node_temp),
        .s_node_depth   (s_node_depth),
        .s_profile_start(s_profile_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_front_kind   (m_front_kind),
        .m_front_depth  (m_front_depth),
        .m_front_slot   (m_front_slot),
        .m_thaw_count   (m_thaw_count),
        .m_frost_count  (m_frost_count)
    );

    ftff_front_checker #(
        .FRONT_LIMIT(FRONT_LIMIT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_node_temp    (s_node_temp),
        .s_node_depth   (s_node_depth),
        .s_profile_start(s_profile_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_front_kind   (m_front_kind),
        .m_front_depth  (m_front_depth),
        .m_front_slot   (m_front_slot),
        .m_thaw_count   (m_thaw_count),
        .m_frost_count  (m_frost_count),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Raise a request and hold it until the block takes it. Valid is left high so
    // a back-to-back request does not drop it for a cycle.
    task automatic offer_node(input int temp, input int depth, input bit start);
        s_node_temp     <= TEMP_W'(temp);
        s_node_depth    <= DEPTH_W'(depth);
        s_profile_start <= start;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic sender_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop requesting and wait for every outstanding report. The checker's count is
    // updated nonblocking, so what we read here reflects all earlier edges.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // only issued while idle: no request outstanding, no report pending
    task automatic write_threshold(input int value);
        cfg_wr_data <= TEMP_W'(value);
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly temperatures hugging the threshold at a random scale so fronts are common;
    // some full-range values so every bit toggles, some exactly on the threshold.
    function automatic int pick_temp(int thr);
        int spread;
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = int'($urandom_range(0, DEPTH_MAX)) + TEMP_MIN;
            2: v = thr;
            default: begin
                spread = 1 << int'($urandom_range(0, 17));
                v = thr + int'($urandom_range(0, 2 * spread)) - spread;
            end
        endcase
        if (v > TEMP_MAX) v = TEMP_MAX;
        if (v < TEMP_MIN) v = TEMP_MIN;
        return v;
    endfunction

    // One soil profile: deepest node first with the start flag, then nodes moving up.
    // A few profiles lose their start flag, a few nodes get a stray one, and some
    // depths jump out of order, so broken sequences show up among the good ones.
    task automatic offer_profile();
        int len;
        int depth;
        bit start;
        bit gappy;
        len   = ($urandom_range(0, 9) == 0) ? 1 : int'($urandom_range(2, 12));
        gappy = ($urandom_range(0, 1) == 1);
        depth = int'($urandom_range(0, DEPTH_MAX));
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                start = ($urandom_range(0, 9) != 0);
            end else begin
                start = ($urandom_range(0, 29) == 0);
                if ($urandom_range(0, 6) == 0) begin
                    depth = int'($urandom_range(0, DEPTH_MAX));
                end else begin
                    depth -= int'($urandom_range(0, 1 << int'($urandom_range(0, 16))));
                    if (depth < 0) depth = 0;
                end
            end
            offer_node(pick_temp(cur_thr), depth, start);
            items_sent++;
            if (rush_left > 0) begin
                rush_left--;
            end else if (!calm && gappy && $urandom_range(0, 2) == 0) begin
                sender_gap(int'($urandom_range(1, 18)));
            end
        end
    endtask

    // Receiver: random ready bursts and stalls, a long hold-off on request from the
    // stimulus side, and ready held high once the run goes calm.
    initial begin : sink
        int n;
        @(posedge aclk);
        forever begin
            if (holds_done < holds_asked) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                n = calm ? 1 : int'($urandom_range(1, 40));
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int  thr0;
        int  phase_end;
        bit  drained;
        thr0 = int'(THR_RESET);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cur_thr = thr0;

        // Directed part at the reset threshold.
        // First node after reset with no start flag: nothing below it yet.
        offer_node(0, 500, 1'b0);
        // warmest node over a cold one, shallowest depth: thaw front before any profile
        offer_node(TEMP_MAX, 0, 1'b0);
        // coldest node at the deepest depth opens a profile and clears the counts
        offer_node(TEMP_MIN, DEPTH_MAX, 1'b1);
        // exactly on the threshold: neither warmer nor colder
        offer_node(thr0, 900000, 1'b0);
        // lower node sits on the threshold: still counts as not warmer
        offer_node(thr0 + 1, 800000, 1'b0);
        offer_node(thr0 - 1, 700000, 1'b0);
        // alternate until both lists fill, then one more of each kind is dropped
        offer_node(TEMP_MAX, 600000, 1'b0);
        offer_node(TEMP_MIN, 500000, 1'b0);
        offer_node(TEMP_MAX, 400000, 1'b0);
        offer_node(TEMP_MIN, 300000, 1'b0);
        offer_node(TEMP_MAX, 200000, 1'b0);
        offer_node(TEMP_MIN, 100000, 1'b0);
        // new profile in the middle of a full one
        offer_node(thr0, 0, 1'b1);
        // upper node deeper than the lower one: interpolation runs backwards
        offer_node(thr0 - 100, DEPTH_MAX, 1'b0);
        // equal depths on both nodes
        offer_node(thr0 + 100, DEPTH_MAX, 1'b0);
        offer_node(thr0 + 200, 0, 1'b0);
        offer_node(thr0 - 5, DEPTH_MAX, 1'b0);
        offer_node(0, 0, 1'b1);
        offer_node(0, 0, 1'b0);
        offer_node(TEMP_MAX, DEPTH_MAX, 1'b0);
        offer_node(TEMP_MIN, 0, 1'b0);

        // Random phases, each at its own threshold; extremes first, reset value again later.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: cur_thr = TEMP_MIN;
                1: cur_thr = TEMP_MAX;
                2: cur_thr = 0;
                5: cur_thr = thr0;
                default: cur_thr = int'($urandom_range(0, DEPTH_MAX)) + TEMP_MIN;
            endcase
            write_threshold(cur_thr);
            if (ph == 1) begin
                // receiver holds off while the sender keeps pushing requests back to back
                holds_asked <= holds_asked + 1;
                rush_left = 40;
            end
            if (ph == PHASES - 1) begin
                calm <= 1'b1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            drained   = 1'b0;
            while (items_sent < phase_end) begin
                if (ph == 2 && !drained && items_sent > phase_end - PHASE_ITEMS / 2) begin
                    // sender pauses until every outstanding report is back
                    drain_results();
                    drained = 1'b1;
                end
                offer_profile();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
